// ===== hw/rtl/abld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abld_pkg
// Shared types and constants of the audio block level detector.
// ----------------------------------------------------------------------------
package abld_pkg;

  localparam int unsigned WINDOW_DEF      = 32;
  localparam int unsigned MAX_SAMPLES_DEF = 4096;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned STEP_W   = $clog2(LEVEL_W);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic               audio_active;
    logic [LEVEL_W-1:0] block_level;
    logic [LEVEL_W-1:0] new_average;
    logic               too_long;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_LVL,
    BK_UPDATE,
    BK_DIV_AVG,
    BK_FINISH
  } back_state_e;

endpackage
`default_nettype wire

// ===== hw/rtl/abld_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abld_front
// Accumulates sample magnitudes and counts per buffer; hands a finished
// buffer's totals to the job queue on the marked sample.
// ----------------------------------------------------------------------------
module abld_front #(
  parameter int unsigned MAX_SAMPLES = abld_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned SUM_W       = 28,
  parameter int unsigned CNT_W       = 13
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire abld_pkg::in_item_t in_data_i,
  output logic                   push_valid_o,
  input  wire                    push_ready_i,
  output logic [SUM_W-1:0]       push_sum_o,
  output logic [CNT_W-1:0]       push_cnt_o,
  output logic                   push_ovf_o
);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [abld_pkg::SAMPLE_W-1:0] mag;
  logic             take;

  // -32768 wraps to 0x8000, which is its magnitude as unsigned
  assign mag = in_data_i.sample[abld_pkg::SAMPLE_W-1]
             ? abld_pkg::SAMPLE_W'(-in_data_i.sample)
             : abld_pkg::SAMPLE_W'(in_data_i.sample);

  // stall everything while the queue is full so a marked item is never lost
  assign in_ready_o = push_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cnt_q < CNT_W'(MAX_SAMPLES)) begin
      sum_d = sum_q + SUM_W'(mag);
      cnt_d = cnt_q + CNT_W'(1);
    end else begin
      ovf_d = 1'b1;
    end
  end

  assign push_valid_o = in_valid_i && in_data_i.last_in_buffer;
  assign push_sum_o   = sum_d;
  assign push_cnt_o   = cnt_d;
  assign push_ovf_o   = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else if (take) begin
      if (in_data_i.last_in_buffer) begin
        sum_q <= '0;
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
        ovf_q <= ovf_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/abld_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abld_queue
// Two-entry job queue between the accumulator and the divider side.
// ----------------------------------------------------------------------------
module abld_queue #(
  parameter int unsigned DATA_W = 42
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_valid_i,
  output logic              push_ready_o,
  input  wire [DATA_W-1:0]  push_data_i,
  output logic              pop_valid_o,
  input  wire               pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  logic [DATA_W-1:0] slot_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        fill_q;
  logic              do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/abld_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abld_back
// Per-buffer work: level = sum / count, window update, average = total /
// WINDOW. Restoring divider for the level, one quotient bit per cycle; the
// average is a single multiply by the reciprocal of WINDOW.
// ----------------------------------------------------------------------------
module abld_back #(
  parameter int unsigned WINDOW = abld_pkg::WINDOW_DEF,
  parameter int unsigned SUM_W  = 28,
  parameter int unsigned CNT_W  = 13
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      job_valid_i,
  output logic                     job_ready_o,
  input  wire [SUM_W-1:0]          job_sum_i,
  input  wire [CNT_W-1:0]          job_cnt_i,
  input  wire                      job_ovf_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output abld_pkg::out_item_t      out_data_o
);

  localparam int unsigned LW    = abld_pkg::LEVEL_W;
  localparam int unsigned SW    = abld_pkg::STEP_W;
  localparam int unsigned TOT_W = $clog2(WINDOW * 32768 + 1);
  localparam int unsigned DW    = SUM_W;
  localparam int unsigned SH_W  = CNT_W + LW - 1;
  localparam int unsigned CMP_W = (DW > SH_W) ? DW : SH_W;
  localparam int unsigned PTR_W = $clog2(WINDOW);

  // total / WINDOW == (total * AVG_M) >> AVG_SH for every TOT_W-bit total
  localparam int unsigned M_W    = TOT_W + 1;
  localparam int unsigned AVG_SH = TOT_W + $clog2(WINDOW);
  localparam int unsigned PROD_W = TOT_W + M_W;
  localparam logic [M_W-1:0] AVG_M =
    M_W'(((64'd1 << AVG_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  abld_pkg::back_state_e state_q, state_d;

  // divider
  logic [DW-1:0]   rem_q;
  logic [SH_W-1:0] sh_q;
  logic [LW-1:0]   quo_q;
  logic [SW-1:0]   step_q;
  logic            ge;
  logic [CMP_W-1:0] rem_x, sh_x;

  // window store
  logic [LW-1:0]     win_mem [WINDOW];
  logic [WINDOW-1:0] win_vld_q;
  logic [PTR_W-1:0]  ptr_q;
  logic [LW-1:0]     old_q;
  logic              old_vld_q;
  logic [TOT_W-1:0]  total_q, total_nx;
  logic [LW-1:0]     old_lvl;
  logic [PROD_W-1:0] avg_prod;

  logic [LW-1:0] avg_q, level_q;
  logic          active_q, ovf_q;

  logic start, load_out;
  abld_pkg::out_item_t out_q;
  logic out_vld_q;

  assign rem_x = CMP_W'(rem_q);
  assign sh_x  = CMP_W'(sh_q);
  assign ge    = (rem_x >= sh_x);

  assign old_lvl  = old_vld_q ? old_q : '0;
  assign total_nx = total_q - TOT_W'(old_lvl) + TOT_W'(quo_q);
  assign avg_prod = PROD_W'(total_q) * PROD_W'(AVG_M);

  always_comb begin
    state_d     = state_q;
    job_ready_o = 1'b0;
    start       = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      abld_pkg::BK_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          start   = 1'b1;
          state_d = abld_pkg::BK_DIV_LVL;
        end
      end
      abld_pkg::BK_DIV_LVL: begin
        if (step_q == SW'(LW - 1)) state_d = abld_pkg::BK_UPDATE;
      end
      abld_pkg::BK_UPDATE: begin
        state_d = abld_pkg::BK_DIV_AVG;
      end
      abld_pkg::BK_DIV_AVG: begin
        state_d = abld_pkg::BK_FINISH;
      end
      abld_pkg::BK_FINISH: begin
        if (!out_vld_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = abld_pkg::BK_IDLE;
        end
      end
      default: state_d = abld_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abld_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath without reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      abld_pkg::BK_IDLE: begin
        if (start) begin
          rem_q     <= DW'(job_sum_i);
          sh_q      <= SH_W'(job_cnt_i) << (LW - 1);
          step_q    <= '0;
          ovf_q     <= job_ovf_i;
          old_q     <= win_mem[ptr_q];
          old_vld_q <= win_vld_q[ptr_q];
        end
      end
      abld_pkg::BK_DIV_LVL: begin
        if (ge) rem_q <= DW'(rem_x - sh_x);
        quo_q  <= {quo_q[LW-2:0], ge};
        sh_q   <= sh_q >> 1;
        step_q <= step_q + SW'(1);
      end
      abld_pkg::BK_UPDATE: begin
        level_q  <= quo_q;
        active_q <= (quo_q > avg_q);
        win_mem[ptr_q] <= quo_q;
      end
      abld_pkg::BK_DIV_AVG: begin
        // total_q already holds the updated window sum
        quo_q <= avg_prod[AVG_SH +: LW];
      end
      default: begin
      end
    endcase
  end

  // control and reset-cleared state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_vld_q <= '0;
      ptr_q     <= '0;
      total_q   <= '0;
      avg_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (state_q == abld_pkg::BK_UPDATE) begin
        win_vld_q[ptr_q] <= 1'b1;
        total_q          <= total_nx;
        ptr_q            <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);
      end
      if (load_out) begin
        avg_q     <= quo_q;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.audio_active <= active_q;
      out_q.block_level  <= level_q;
      out_q.new_average  <= quo_q;
      out_q.too_long     <= ovf_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/audio_block_level_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_block_level_detector
// Mean absolute level per buffer, compared against a moving average.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one signed sample per
// item, last_in_buffer marks the end of a buffer. Items are taken one per
// cycle. Samples past MAX_SAMPLES are dropped and flagged too_long.
// A marked item pushes the buffer totals into a 2-deep job queue; the input
// stalls only while that queue is full.
// Output channel (out_valid_o / out_ready_i / out_data_o): one item per
// buffer. After the marked item is accepted, the job leaves the queue, a
// restoring divider forms sum/count (one quotient bit a cycle), then come
// the window update, the average by a reciprocal multiply and the output
// register load, which sets out_valid_o. The back side works on one
// buffer at a time; buffers that arrive while it is busy queue up.
// The result sits in an output register, so the back side can start the
// next buffer while the receiver stalls; it waits only to reload that reg.
// Reset: all accumulators, the window total, the average and the per-entry
// valid bits of the window store clear at once; no clearing pass.
// ----------------------------------------------------------------------------
module audio_block_level_detector #(
  parameter int unsigned WINDOW      = abld_pkg::WINDOW_DEF,
  parameter int unsigned MAX_SAMPLES = abld_pkg::MAX_SAMPLES_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire abld_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output abld_pkg::out_item_t      out_data_o
);

  // widths of the per-buffer totals
  localparam int unsigned SUM_W = $clog2(64'(MAX_SAMPLES) * 64'd32768 + 64'd1);
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned JOB_W = SUM_W + CNT_W + 1;

  logic             push_valid, push_ready;
  logic [SUM_W-1:0] push_sum;
  logic [CNT_W-1:0] push_cnt;
  logic             push_ovf;
  logic             job_valid, job_ready;
  logic [JOB_W-1:0] job_data;

  abld_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_sum_o   (push_sum),
    .push_cnt_o   (push_cnt),
    .push_ovf_o   (push_ovf)
  );

  // job word: {sum, count, overflow}
  abld_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_sum, push_cnt, push_ovf}),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_ready),
    .pop_data_o   (job_data)
  );

  abld_back #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .CNT_W  (CNT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_sum_i   (job_data[JOB_W-1 -: SUM_W]),
    .job_cnt_i   (job_data[CNT_W:1]),
    .job_ovf_i   (job_data[0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the audio block level detector against an in-bench prediction of
// the per-buffer mean magnitude, the activity flag, the 32-entry moving
// average and the too-long flag. Directed buffers come first, then random
// buffers with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned WIN            = abld_pkg::WINDOW_DEF;
  localparam int unsigned MAX_TAKEN      = abld_pkg::MAX_SAMPLES_DEF;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned CALM_ITEMS     = 800;   // no idling after this many
  localparam int unsigned SETTLE_CYCLES  = 2 * abld_pkg::LEVEL_W + 30;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // Tracks the detector state and holds the results still owed by the DUT.
  class level_scoreboard;
    logic [abld_pkg::LEVEL_W-1:0] history[WIN];
    int unsigned          oldest;
    int unsigned          hist_total;
    int unsigned          avg_now;
    int unsigned          taken;
    longint unsigned      mag_sum;
    bit                   dropped;
    abld_pkg::out_item_t  owed_q[$];
    int unsigned          errors;
    int unsigned          samples;
    int unsigned          buffers;
    int unsigned          long_bufs;
    int unsigned          active_bufs;

    function new();
      foreach (history[i]) history[i] = '0;
      oldest      = 0;
      hist_total  = 0;
      avg_now     = 0;
      taken       = 0;
      mag_sum     = 0;
      dropped     = 1'b0;
      errors      = 0;
      samples     = 0;
      buffers     = 0;
      long_bufs   = 0;
      active_bufs = 0;
    endfunction

    // Called for every accepted sample item.
    function void note_sample(abld_pkg::in_item_t it);
      int                  s;
      int unsigned         mag;
      int unsigned         lvl;
      abld_pkg::out_item_t want;
      s   = $signed(it.sample);
      mag = (s < 0) ? -s : s;   // -32768 gives 32768
      samples++;
      if (taken < MAX_TAKEN) begin
        mag_sum += mag;
        taken++;
      end else begin
        dropped = 1'b1;
      end
      if (!it.last_in_buffer) return;

      lvl = (taken != 0) ? 32'(mag_sum / taken) : 0;
      want.audio_active = (lvl > avg_now);
      hist_total = hist_total - history[oldest] + lvl;
      history[oldest] = lvl[abld_pkg::LEVEL_W-1:0];
      oldest = (oldest + 1 == WIN) ? 0 : oldest + 1;
      avg_now = hist_total / WIN;
      want.block_level = lvl[abld_pkg::LEVEL_W-1:0];
      want.new_average = avg_now[abld_pkg::LEVEL_W-1:0];
      want.too_long    = dropped;
      owed_q.push_back(want);

      buffers++;
      if (dropped) long_bufs++;
      if (want.audio_active) active_bufs++;
      mag_sum = 0;
      taken   = 0;
      dropped = 1'b0;
    endfunction

    // Called for every accepted result item.
    function void check_result(abld_pkg::out_item_t got);
      abld_pkg::out_item_t want;
      if (owed_q.size() == 0) begin
        $error("result with no buffer pending: block_level %0d", got.block_level);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.audio_active !== want.audio_active) begin
        $error("audio_active: expected %0d, got %0d", want.audio_active, got.audio_active);
        errors++;
      end
      if (got.block_level !== want.block_level) begin
        $error("block_level: expected %0d, got %0d", want.block_level, got.block_level);
        errors++;
      end
      if (got.new_average !== want.new_average) begin
        $error("new_average: expected %0d, got %0d", want.new_average, got.new_average);
        errors++;
      end
      if (got.too_long !== want.too_long) begin
        $error("too_long: expected %0d, got %0d", want.too_long, got.too_long);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  abld_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  abld_pkg::out_item_t out_data;

  // Shared switch: when low, neither side starts a new gap or stall.
  bit idling_on;

  level_scoreboard sb = new();
  int unsigned     quiet_cycles;

  audio_block_level_detector dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Monitor: everything is sampled at the rising edge. The watchdog counts
  // cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if (in_valid && in_ready) sb.note_sample(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: while idling is on, ready starts to drop in random bursts.
  initial begin
    int unsigned hold;
    logic        ready_next;
    hold      = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
        ready_next = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        hold       = $urandom_range(1, 10) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_ready <= ready_next;
    end
  end

  // Offers one sample item and returns at the falling edge after it was
  // taken; the caller must either send again or lower valid right away.
  task automatic send_sample(input logic signed [abld_pkg::SAMPLE_W-1:0] s,
                             input logic last);
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample: s, last_in_buffer: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // One buffer of len random samples with magnitudes up to 2**(amp-1).
  task automatic send_buffer(input int unsigned len, input int unsigned amp);
    logic [31:0]                          raw;
    logic signed [abld_pkg::SAMPLE_W-1:0] s;
    for (int unsigned i = 0; i < len; i++) begin
      raw = $urandom;
      s   = $signed(raw[abld_pkg::SAMPLE_W-1:0]) >>> (abld_pkg::SAMPLE_W - amp);
      send_sample(s, i == len - 1);
    end
  endtask

  // Sender holds off until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int unsigned base;
    int unsigned len;
    int unsigned amp;
    int unsigned pick;
    in_valid  = 1'b0;
    in_data   = '0;
    rst_n     = 1'b0;
    idling_on = 1'b1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes and the magnitude of the most negative sample.
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd5, 1'b0);              // 14 / 3 truncates to 4
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd2, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    wait_drained();

    // Random buffers: mostly short, amplitude varies per buffer so the
    // level swings around the moving average.
    base = sb.samples;
    while (sb.samples - base < RANDOM_ITEMS) begin
      idling_on = (sb.samples - base < CALM_ITEMS) && ($urandom_range(0, 5) != 0);
      pick = $urandom_range(0, 19);
      if (pick < 15)      len = $urandom_range(1, 16);
      else if (pick < 19) len = $urandom_range(17, 64);
      else                len = $urandom_range(65, 300);
      amp = $urandom_range(1, abld_pkg::SAMPLE_W);
      send_buffer(len, amp);
      if ($urandom_range(0, 30) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d samples in %0d buffers: %0d too long, %0d active.",
             sb.samples, sb.buffers, sb.long_bufs, sb.active_bufs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
